### src/ctrl_pkg.sv
// Shared types and constants for the call transition range lookup.
package ctrl_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 1024;
    localparam int DEFAULT_ADDR_WIDTH = 64;
    localparam int MAX_CNT_W = 17;
    localparam logic [31:0] WINDOW_RESET = 32'h0001_0000;

    typedef enum logic [1:0] {
        CMD_NOP,
        CMD_LOAD,
        CMD_FULL,
        CMD_CALL
    } cmd_kind_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SCAN,
        BK_DRAIN,
        BK_FIN,
        BK_EMIT
    } back_state_t;

    typedef struct packed {
        logic        func;
        logic [63:0] address;
        logic        in_executable;
        logic        module_named;
    } in_item_t;

    typedef struct packed {
        logic        call_detected;
        logic [9:0]  function_index;
        logic [31:0] call_offset;
        logic        table_full;
    } out_item_t;

    typedef struct packed {
        cmd_kind_t              kind;
        logic [63:0]            addr;
        logic [MAX_CNT_W-1:0]   count;
    } cmd_t;

endpackage

### src/ctrl_fifo.sv
// Small register queue used between the front, the back and the result port.
module ctrl_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = slots_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slots_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### src/ctrl_front.sv
// Front end: accepts items, tracks trace history and table fill, classifies commands.
module ctrl_front import ctrl_pkg::*; #(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
    parameter int ADDR_WIDTH  = DEFAULT_ADDR_WIDTH
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     accept,
    input  in_item_t item,
    output logic     cmd_push,
    output cmd_t     cmd
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    logic [CNT_W-1:0]      fill_reg;
    logic                  have_prev_reg;
    logic                  prev_exe_reg;
    logic                  prev_named_reg;
    logic [ADDR_WIDTH-1:0] addr_m;
    logic                  room;
    logic                  is_call;

    assign addr_m   = item.address[ADDR_WIDTH-1:0];
    assign room     = (fill_reg < CNT_W'(TABLE_DEPTH));
    assign is_call  = have_prev_reg && item.module_named && prev_named_reg &&
                      !item.in_executable && prev_exe_reg;
    assign cmd_push = accept;

    always_comb
    begin
        cmd.addr  = 64'(addr_m);
        cmd.count = MAX_CNT_W'(fill_reg);
        cmd.kind  = CMD_NOP;
        if (!item.func)
        begin
            cmd.kind = room ? CMD_LOAD : CMD_FULL;
        end
        else if (addr_m != '0 && is_call)
        begin
            cmd.kind = CMD_CALL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg       <= '0;
            have_prev_reg  <= 1'b0;
            prev_exe_reg   <= 1'b0;
            prev_named_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (!item.func)
            begin
                if (room)
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end
            else if (addr_m != '0)
            begin
                have_prev_reg  <= 1'b1;
                prev_exe_reg   <= item.in_executable;
                prev_named_reg <= item.module_named;
            end
        end
    end

endmodule

### src/ctrl_back.sv
// Back end: owns the start table, scans it for calls and builds the results.
module ctrl_back import ctrl_pkg::*; #(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
    parameter int ADDR_WIDTH  = DEFAULT_ADDR_WIDTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    input  logic        cmd_empty,
    output logic        cmd_pop,
    input  logic [31:0] window,
    input  logic        res_full,
    output logic        res_push,
    output out_item_t   res
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W = $clog2(TABLE_DEPTH);

    logic [ADDR_WIDTH-1:0] table_mem [TABLE_DEPTH];

    back_state_t           state_reg;
    back_state_t           state_next;
    logic [ADDR_WIDTH-1:0] addr_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      scan_reg;
    logic [ADDR_WIDTH-1:0] rd_data_reg;
    logic [IDX_W-1:0]      rd_idx_reg;
    logic                  rd_valid_reg;
    logic                  found_reg;
    logic [IDX_W-1:0]      best_idx_reg;
    logic [ADDR_WIDTH-1:0] best_start_reg;
    out_item_t             res_reg;
    logic [ADDR_WIDTH-1:0] off;
    logic [IDX_W+9:0]      best_ext;
    logic                  last_read;

    assign off       = addr_reg - best_start_reg;
    assign best_ext  = (IDX_W + 10)'(best_idx_reg);
    assign last_read = (CNT_W'(scan_reg + 1'b1) == cnt_reg);
    assign res       = res_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!cmd_empty)
                begin
                    if (cmd.kind == CMD_CALL && cmd.count != '0)
                    begin
                        state_next = BK_SCAN;
                    end
                    else
                    begin
                        state_next = BK_EMIT;
                    end
                end
            end
            BK_SCAN:
            begin
                if (last_read)
                begin
                    state_next = BK_DRAIN;
                end
            end
            BK_DRAIN: state_next = BK_FIN;
            BK_FIN:   state_next = BK_EMIT;
            BK_EMIT:
            begin
                if (!res_full)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:  state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        cmd_pop  = (state_reg == BK_IDLE) && !cmd_empty;
        res_push = (state_reg == BK_EMIT) && !res_full;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= BK_IDLE;
            rd_valid_reg <= 1'b0;
            found_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_valid_reg <= (state_reg == BK_SCAN);
            if (cmd_pop)
            begin
                found_reg <= 1'b0;
            end
            else if (rd_valid_reg && rd_data_reg <= addr_reg &&
                     (!found_reg || rd_data_reg >= best_start_reg))
            begin
                found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            addr_reg <= cmd.addr[ADDR_WIDTH-1:0];
            cnt_reg  <= cmd.count[CNT_W-1:0];
            scan_reg <= '0;
            res_reg  <= '{call_detected:  1'b0,
                          function_index: '0,
                          call_offset:    '0,
                          table_full:     (cmd.kind == CMD_FULL)};
            if (cmd.kind == CMD_LOAD)
            begin
                table_mem[cmd.count[IDX_W-1:0]] <= cmd.addr[ADDR_WIDTH-1:0];
            end
        end
        if (state_reg == BK_SCAN)
        begin
            rd_data_reg <= table_mem[scan_reg[IDX_W-1:0]];
            rd_idx_reg  <= scan_reg[IDX_W-1:0];
            scan_reg    <= scan_reg + 1'b1;
        end
        if (rd_valid_reg && rd_data_reg <= addr_reg &&
            (!found_reg || rd_data_reg >= best_start_reg))
        begin
            best_idx_reg   <= rd_idx_reg;
            best_start_reg <= rd_data_reg;
        end
        if (state_reg == BK_FIN && found_reg && off < ADDR_WIDTH'(window))
        begin
            res_reg.call_detected  <= 1'b1;
            res_reg.function_index <= best_ext[9:0];
            res_reg.call_offset    <= off[31:0];
        end
    end

endmodule

### src/call_transition_range_lookup.sv
// Top level of the call transition range lookup.
//
//  Channel   Handshake                 Payload
//  input     push / full               item (in_item_t)
//  result    pop / empty               result (out_item_t)
//  config    cfg_valid / cfg_ready     cfg_data (window size)
//
// A load or a non-call trace goes through the command queue, the emit state and
// the result queue. A detected call with a non-empty table scans it one entry per
// cycle through the single memory read port, then steps through drain, finish, emit.
// Reset empties the table, the trace history and both queues; the window is 65536.
// A full result queue stalls the back end, and a full command queue raises full.
module call_transition_range_lookup import ctrl_pkg::*; #(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
    parameter int ADDR_WIDTH  = DEFAULT_ADDR_WIDTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  in_item_t    item,
    input  logic        pop,
    output logic        empty,
    output out_item_t   result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    logic        window_reg;
    logic [31:0] window_val_reg;
    logic        accept;
    logic        cmd_push;
    cmd_t        cmd_in;
    cmd_t        cmd_out;
    logic        cmd_pop;
    logic        cmd_empty;
    out_item_t   res;
    logic        res_push;
    logic        res_full;

    assign cfg_ready = 1'b1;
    assign accept    = push && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg     <= 1'b0;
            window_val_reg <= WINDOW_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            window_reg     <= 1'b1;
            window_val_reg <= cfg_data;
        end
    end

    ctrl_front #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .item    (item),
        .cmd_push(cmd_push),
        .cmd     (cmd_in)
    );

    ctrl_fifo #(
        .WIDTH($bits(cmd_t)),
        .DEPTH(2)
    ) u_cmd_q (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (cmd_push),
        .wr_data(cmd_in),
        .rd_en  (cmd_pop),
        .rd_data(cmd_out),
        .full   (full),
        .empty  (cmd_empty)
    );

    ctrl_back #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd_out),
        .cmd_empty(cmd_empty),
        .cmd_pop  (cmd_pop),
        .window   (window_val_reg),
        .res_full (res_full),
        .res_push (res_push),
        .res      (res)
    );

    ctrl_fifo #(
        .WIDTH($bits(out_item_t)),
        .DEPTH(2)
    ) u_res_q (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (res_push),
        .wr_data(res),
        .rd_en  (pop),
        .rd_data(result),
        .full   (res_full),
        .empty  (empty)
    );

    assert property (@(posedge clk) disable iff (!rst_n) cmd_pop |-> !cmd_empty)
        else $error("back end popped an empty command queue");
    assert property (@(posedge clk) disable iff (!rst_n) res_push |-> !res_full)
        else $error("back end pushed into a full result queue");
    assert property (@(posedge clk) disable iff (!rst_n) res_push |=> !empty)
        else $error("pushed result not visible");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && !window_reg) |=> window_reg)
        else $error("window write lost");

endmodule
